### rtl/glb_pkg.sv
// Package for the line blur: sizes, register indexes, reset weights and the
// beat type passed from the window stage to the multiply-accumulate stages.
// No dependencies.
`timescale 1ns / 1ps

package glb_pkg;

  // Kernel and data sizes
  localparam int MAX_RADIUS = 6;
  localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int NUM_COEFS  = MAX_RADIUS + 1;
  localparam int COEF_BITS  = 16;
  localparam int VOX_W      = 8;
  localparam int PAIR_W     = VOX_W + 1;
  localparam int PROD_W     = PAIR_W + COEF_BITS;
  localparam int SUM_W      = PROD_W + 3;
  localparam int RAD_W      = 3;
  localparam int CNT_W      = 4;
  localparam int IDX_W      = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_RADIUS      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_CENTER = 3'd1;

  // Reset values
  localparam logic [RAD_W-1:0] RADIUS_RST = 3'd2;
  localparam logic [COEF_BITS-1:0] COEF_RST [NUM_COEFS] = '{
    16'd23768, 16'd15723, 16'd4552, 16'd0, 16'd0, 16'd0, 16'd0
  };

  typedef logic [NUM_COEFS-1:0][COEF_BITS-1:0] coef_array_t;
  typedef logic [NUM_COEFS-1:0][PAIR_W-1:0]    pair_array_t;

  // One result in flight: symmetric pair sums plus its flags
  typedef struct packed {
    pair_array_t pair;
    logic        end_of_run;
    logic        line_done;
  } tap_beat_t;

endpackage

### rtl/glb_window.sv
// Sample window, line position counter and result sequencer for the blur.
// Gathers the clamped samples of each result into symmetric pair sums.
// Depends on glb_pkg.
`timescale 1ns / 1ps

module glb_window
  import glb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [VOX_W-1:0] voxel_in,
  input  logic             last_in_line,
  input  logic [RAD_W-1:0] rad,
  output logic             tap_valid,
  input  logic             tap_ready,
  output tap_beat_t        tap_beat
);

  // Window, newest sample at entry 0
  logic [VOX_W-1:0] win [WIN_DEPTH];
  logic [CNT_W-1:0] seen;

  // Pending results of the current beat
  logic             job_valid;
  logic [RAD_W-1:0] job_t;
  logic [RAD_W-1:0] job_hi;
  logic [CNT_W-1:0] job_j;
  logic             job_last;
  logic [RAD_W-1:0] job_rad;

  logic      s1_adv;
  logic      issue;
  logic      in_fire;
  logic      job_end;
  tap_beat_t beat_next;

  assign s1_adv  = !tap_valid || tap_ready;
  assign issue   = job_valid && s1_adv;
  assign job_end = issue && (job_t == job_hi);
  assign in_ready = !job_valid || job_end;
  assign in_fire  = in_valid && in_ready;

  // Window shift and line position
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_DEPTH; i++) win[i] <= '0;
      seen <= '0;
    end else if (in_fire) begin
      win[0] <= voxel_in;
      for (int i = 1; i < WIN_DEPTH; i++) win[i] <= win[i-1];
      if (last_in_line) begin
        seen <= '0;
      end else if (seen < CNT_W'(WIN_DEPTH - 1)) begin
        seen <= seen + CNT_W'(1);
      end
    end
  end

  // Sequencer: a last voxel flushes every result still owed on the line
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_t     <= '0;
      job_hi    <= '0;
      job_j     <= '0;
      job_last  <= 1'b0;
      job_rad   <= '0;
    end else if (in_fire) begin
      job_j    <= seen;
      job_last <= last_in_line;
      job_rad  <= rad;
      if (last_in_line) begin
        job_valid <= 1'b1;
        job_hi    <= rad;
        if ({1'b0, rad} > seen) begin
          job_t <= RAD_W'({1'b0, rad} - seen);
        end else begin
          job_t <= '0;
        end
      end else begin
        job_valid <= ({1'b0, rad} <= seen);
        job_t     <= '0;
        job_hi    <= '0;
      end
    end else if (issue) begin
      if (job_t == job_hi) begin
        job_valid <= 1'b0;
      end else begin
        job_t <= job_t + RAD_W'(1);
      end
    end
  end

  // Gather clamped samples into pair sums for the current result
  always_comb begin
    logic signed [5:0] c;
    logic signed [5:0] bp;
    logic signed [5:0] bm;
    logic        [IDX_W-1:0] dp;
    logic        [IDX_W-1:0] dm;
    c = 6'(signed'({3'b000, job_rad})) - 6'(signed'({3'b000, job_t}));
    beat_next.end_of_run = (job_t == job_hi);
    beat_next.line_done  = job_last && (job_t == job_hi);
    for (int a = 0; a < NUM_COEFS; a++) begin
      bp = c - 6'(a);
      bm = c + 6'(a);
      if (bp < 0) dp = '0;
      else if (bp > signed'({2'b00, job_j})) dp = job_j;
      else dp = IDX_W'(bp);
      if (bm < 0) dm = '0;
      else if (bm > signed'({2'b00, job_j})) dm = job_j;
      else dm = IDX_W'(bm);
      if (a == 0) begin
        beat_next.pair[a] = {1'b0, win[dp]};
      end else if (RAD_W'(a) <= job_rad) begin
        beat_next.pair[a] = {1'b0, win[dp]} + {1'b0, win[dm]};
      end else begin
        beat_next.pair[a] = '0;
      end
    end
  end

  // Gather register
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_valid <= 1'b0;
    end else if (s1_adv) begin
      tap_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      tap_beat <= beat_next;
    end
  end

endmodule

### rtl/glb_mac.sv
// Multiply and accumulate stages of the blur: one product per pair sum,
// then the sum, shift, saturation and result register.
// Depends on glb_pkg.
`timescale 1ns / 1ps

module glb_mac
  import glb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             tap_valid,
  output logic             tap_ready,
  input  tap_beat_t        tap_beat,
  input  coef_array_t      coefs,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VOX_W-1:0] blurred,
  output logic             end_of_run,
  output logic             line_done
);

  logic              s2_valid;
  logic [PROD_W-1:0] prod [NUM_COEFS];
  logic              s2_eor;
  logic              s2_done;
  logic              out_adv;
  logic              s2_adv;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-COEF_BITS-1:0] shifted;

  assign out_adv   = !out_valid || out_ready;
  assign s2_adv    = !s2_valid || out_adv;
  assign tap_ready = s2_adv;

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= tap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      for (int a = 0; a < NUM_COEFS; a++) begin
        prod[a] <= PROD_W'(tap_beat.pair[a]) * PROD_W'(coefs[a]);
      end
      s2_eor  <= tap_beat.end_of_run;
      s2_done <= tap_beat.line_done;
    end
  end

  // Sum, truncate and saturate
  always_comb begin
    sum = '0;
    for (int a = 0; a < NUM_COEFS; a++) begin
      sum = sum + SUM_W'(prod[a]);
    end
    shifted = sum[SUM_W-1:COEF_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      if (shifted > (SUM_W-COEF_BITS)'(255)) begin
        blurred <= '1;
      end else begin
        blurred <= VOX_W'(shifted);
      end
      end_of_run <= s2_eor;
      line_done  <= s2_done;
    end
  end

endmodule

### rtl/gaussian_line_blur.sv
// Gaussian line blur, one separable pass with clamp-to-edge at both line ends.
// Top level: configuration registers, window/sequencer and multiply stages.
// Depends on glb_pkg, glb_window, glb_mac.
`timescale 1ns / 1ps

// Takes one voxel beat per cycle while in_ready is high. A beat that is
// not the last of its line gives at most one result, delayed by radius
// voxels; the last voxel of a line flushes the results still owed (up to
// radius+1 of them), issued one per cycle by the window sequencer unless
// the multiply stages stall it, and the input is held until they issue.
// A result passes the gather, product and result registers. Weights are
// Q0.16; software must set them with the radius only while the block is
// idle, which the block does not enforce. A radius above six acts as six.
module gaussian_line_blur
  import glb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VOX_W-1:0]      voxel_in,
  input  logic                  last_in_line,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VOX_W-1:0]      blurred,
  output logic                  end_of_run,
  output logic                  line_done
);

  logic [RAD_W-1:0] radius;
  coef_array_t      coefs;
  logic [RAD_W-1:0] rad_eff;
  logic             tap_valid;
  logic             tap_ready;
  tap_beat_t        tap_beat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RST;
      for (int a = 0; a < NUM_COEFS; a++) coefs[a] <= COEF_RST[a];
    end else if (cfg_wr_en) begin
      if (cfg_addr == REG_RADIUS) begin
        radius <= cfg_wdata[RAD_W-1:0];
      end else begin
        coefs[CFG_ADDR_W'(cfg_addr - REG_COEF_CENTER)] <= cfg_wdata[COEF_BITS-1:0];
      end
    end
  end

  // Radius limited to the window size
  assign rad_eff = (radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius;

  glb_window u_window (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .voxel_in     (voxel_in),
    .last_in_line (last_in_line),
    .rad          (rad_eff),
    .tap_valid    (tap_valid),
    .tap_ready    (tap_ready),
    .tap_beat     (tap_beat)
  );

  glb_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .tap_valid  (tap_valid),
    .tap_ready  (tap_ready),
    .tap_beat   (tap_beat),
    .coefs      (coefs),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .blurred    (blurred),
    .end_of_run (end_of_run),
    .line_done  (line_done)
  );

endmodule

### verif/tb_top.sv
// Self-checking testbench for gaussian_line_blur: random and directed voxel lines
// against a line-blur predictor held in a small tracking class.
// Depends on glb_pkg and the gaussian_line_blur RTL.
`timescale 1ns / 1ps

module tb_top;
  import glb_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BEATS = 400;
  localparam int IDLE_PCT     = 38;
  localparam int HOLD_CYCLES  = 90;
  localparam int SETTLE       = 8;

  typedef enum {VOX_RANDOM, VOX_FULL, VOX_EMPTY, VOX_SPIKY} fill_kind_t;
  typedef enum {KERN_GAUSS, KERN_RANDOM, KERN_FULL, KERN_ZERO, KERN_MILD} kernel_kind_t;

  // Line-blur predictor plus the queue of blurred voxels still owed
  class blur_tracker;
    typedef struct {
      logic [VOX_W-1:0] pixel;
      logic             end_of_run;
      logic             line_done;
    } blur_out_t;

    logic [VOX_W-1:0]     window [WIN_DEPTH];
    int                   seen;
    logic [RAD_W-1:0]     radius;
    logic [COEF_BITS-1:0] weight [NUM_COEFS];
    blur_out_t            owed [$];
    int                   errors;

    function new();
      foreach (window[i]) window[i] = '0;
      foreach (weight[i]) weight[i] = COEF_RST[i];
      seen   = 0;
      radius = RADIUS_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      if (addr == REG_RADIUS)
        radius = data[RAD_W-1:0];
      else
        weight[addr - REG_COEF_CENTER] = data[COEF_BITS-1:0];
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Shift the voxel in, then work out every result this beat releases
    function void take_voxel(logic [VOX_W-1:0] v, logic last);
      int rad, lo, hi, back, d, a, i, t, k;
      longint unsigned acc;
      blur_out_t r;
      rad = (radius > MAX_RADIUS) ? MAX_RADIUS : int'(radius);
      for (i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = v;

      if (last) begin
        lo = (rad > seen) ? rad - seen : 0;
        hi = rad;
      end else if (seen >= rad) begin
        lo = 0;
        hi = 0;
      end else begin
        // still warming up: nothing owed yet
        lo = 1;
        hi = 0;
      end

      for (t = lo; t <= hi; t++) begin
        acc = 0;
        for (k = -rad; k <= rad; k++) begin
          back = rad - t - k;
          // clamp to the line ends: oldest voxel of the line or newest one
          d = (back < 0) ? 0 : ((back > seen) ? seen : back);
          if (d >= WIN_DEPTH) d = WIN_DEPTH - 1;
          a = (k < 0) ? -k : k;
          if (a < NUM_COEFS) acc += 64'(window[d]) * 64'(weight[a]);
        end
        r.pixel      = ((acc >> COEF_BITS) > 255) ? {VOX_W{1'b1}} : acc[COEF_BITS +: VOX_W];
        r.end_of_run = (t == hi);
        r.line_done  = last && (t == hi);
        owed.push_back(r);
      end

      if (last)
        seen = 0;
      else if (seen < 2 * MAX_RADIUS)
        seen++;
    endfunction

    task flag_mismatch(string what, int got, int want);
      errors++;
      $display("tb_top: %s mismatch at %0t: got %0d, want %0d", what, $realtime, got, want);
    endtask

    task match_result(logic [VOX_W-1:0] pixel, logic eor, logic done);
      blur_out_t want;
      if (owed.size() == 0) begin
        flag_mismatch("unexpected beat", pixel, -1);
        return;
      end
      want = owed.pop_front();
      if (pixel !== want.pixel) flag_mismatch("blurred", pixel, want.pixel);
      if (eor !== want.end_of_run) flag_mismatch("end_of_run", eor, want.end_of_run);
      if (done !== want.line_done) flag_mismatch("line_done", done, want.line_done);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [VOX_W-1:0]      voxel_in;
  logic                  last_in_line;
  logic                  out_valid;
  logic                  out_ready;
  logic [VOX_W-1:0]      blurred;
  logic                  end_of_run;
  logic                  line_done;

  blur_tracker          tracker;
  logic [COEF_BITS-1:0] kernel_w [NUM_COEFS];
  bit                   calm;
  bit                   hold_req;
  int                   hold_left;
  int                   cycle_count;

  gaussian_line_blur dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .voxel_in     (voxel_in),
    .last_in_line (last_in_line),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .blurred      (blurred),
    .end_of_run   (end_of_run),
    .line_done    (line_done)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic bit idle_roll();
    return !calm && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // Weight sets: software-style Gaussian, random, saturating, zero, mild random
  function automatic void fill_kernel(kernel_kind_t kind, int rad);
    int r, a;
    real sigma, g;
    r = (rad > MAX_RADIUS) ? MAX_RADIUS : rad;
    sigma = 0.3 * (r - 1) + 0.8;
    for (a = 0; a < NUM_COEFS; a++) begin
      case (kind)
        KERN_GAUSS: begin
          g = $exp(-real'(a * a) / (2.0 * sigma * sigma)) / (2.5066282746 * sigma) * 65536.0;
          kernel_w[a] = (g > 65535.0) ? 16'hFFFF : COEF_BITS'(int'(g));
        end
        KERN_RANDOM: kernel_w[a] = COEF_BITS'($urandom);
        KERN_FULL:   kernel_w[a] = '1;
        KERN_ZERO:   kernel_w[a] = '0;
        default:     kernel_w[a] = COEF_BITS'($urandom_range(0, 12000));
      endcase
    end
  endfunction

  // Writes radius (junk above the radius field) and all seven weights
  task automatic program_kernel(input logic [RAD_W-1:0] rad);
    logic [CFG_DATA_W-1:0] word;
    int a;
    word = CFG_DATA_W'($urandom);
    word[RAD_W-1:0] = rad;
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_RADIUS;
    cfg_wdata <= word;
    tracker.set_reg(REG_RADIUS, word);
    @(negedge clk);
    for (a = 0; a < NUM_COEFS; a++) begin
      cfg_addr  <= REG_COEF_CENTER + CFG_ADDR_W'(a);
      cfg_wdata <= kernel_w[a];
      tracker.set_reg(REG_COEF_CENTER + CFG_ADDR_W'(a), kernel_w[a]);
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // One voxel beat; called and returns at a falling edge
  task automatic send_voxel(input logic [VOX_W-1:0] v, input logic last);
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    voxel_in     <= v;
    last_in_line <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_voxel(v, last);
    @(negedge clk);
  endtask

  task automatic send_line(input int len, input fill_kind_t kind);
    logic [VOX_W-1:0] v;
    int i;
    for (i = 0; i < len; i++) begin
      case (kind)
        VOX_FULL:  v = '1;
        VOX_EMPTY: v = '0;
        VOX_SPIKY: v = $urandom_range(0, 1) ? '1 : '0;
        default:   v = VOX_W'($urandom);
      endcase
      send_voxel(v, i == len - 1);
    end
  endtask

  // Sender pauses until every owed result is out and the pipe has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idle_roll();
      end
    end
  end

  // Result beats are checked as they are accepted
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.match_result(blurred, end_of_run, line_done);
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  // Main sequence
  initial begin
    int fed, phase, lines, len, sel;
    logic [RAD_W-1:0] rad;
    fill_kind_t fill;
    tracker      = new();
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    voxel_in     = '0;
    last_in_line = 1'b0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset weights, lines of 1, 2 and 5 voxels at the reset radius of 2
    send_line(1, VOX_FULL);
    send_line(2, VOX_SPIKY);
    send_line(5, VOX_RANDOM);
    drain();
    // radius zero, full-scale centre weight
    fill_kernel(KERN_FULL, 0);
    program_kernel(3'd0);
    send_line(3, VOX_FULL);
    send_line(1, VOX_EMPTY);
    drain();
    // radius seven behaves as six; all weights full so the sum saturates
    fill_kernel(KERN_FULL, 7);
    program_kernel(3'd7);
    send_line(4, VOX_FULL);
    drain();
    fill_kernel(KERN_GAUSS, 6);
    program_kernel(3'd6);
    send_line(8, VOX_SPIKY);
    drain();

    // Random phases, each with its own kernel
    fed   = 0;
    phase = 0;
    while (fed < RANDOM_BEATS) begin
      rad = RAD_W'($urandom_range(0, 7));
      fill_kernel(kernel_kind_t'($urandom_range(0, 4)), rad);
      program_kernel(rad);
      calm = (phase == 1);
      if (phase == 2) begin
        // long receiver hold-off while a long line keeps coming
        calm     = 1'b1;
        hold_req = 1'b1;
        send_line(48, VOX_RANDOM);
        fed += 48;
        calm = 1'b0;
      end
      lines = $urandom_range(2, 6);
      repeat (lines) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 32) : $urandom_range(1, 16);
        sel = $urandom_range(0, 9);
        fill = (sel < 7) ? VOX_RANDOM : (sel == 7) ? VOX_FULL : (sel == 8) ? VOX_EMPTY : VOX_SPIKY;
        send_line(len, fill);
        fed += len;
      end
      calm = 1'b0;
      drain();
      phase++;
    end

    repeat (12) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.flag_mismatch("leftover beats", tracker.pending(), 0);
    if (tracker.errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

### filelist.f
rtl/glb_pkg.sv
rtl/glb_window.sv
rtl/glb_mac.sv
rtl/gaussian_line_blur.sv
verif/tb_top.sv
